[rtl/core/tgad_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgad_pkg
// Shared codes, widths and types of the TGA stream decoder.
// ----------------------------------------------------------------------------
package tgad_pkg;

    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int DIM_W    = 16;
    localparam int COUNT_W  = 32;
    localparam int HBC_W    = 5;
    localparam int PHASE_W  = 3;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 112;

    // parse phases
    localparam logic [PHASE_W-1:0] PH_IDLE   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_TYPE   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_INFO   = 3'd2;
    localparam logic [PHASE_W-1:0] PH_RAW    = 3'd3;
    localparam logic [PHASE_W-1:0] PH_RLEHDR = 3'd4;
    localparam logic [PHASE_W-1:0] PH_RLEPIX = 3'd5;
    localparam logic [PHASE_W-1:0] PH_DONE   = 3'd6;
    localparam logic [PHASE_W-1:0] PH_ERROR  = 3'd7;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_PIXEL     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_HDR_OK    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_TYPE  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_INFO  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_TRUNCATED = 3'd5;

    localparam logic [BYTE_W-1:0] TYPE_RAW   = 8'd2;
    localparam logic [BYTE_W-1:0] TYPE_RLE   = 8'd10;
    localparam logic [BYTE_W-1:0] BPP_24     = 8'd24;
    localparam logic [BYTE_W-1:0] BPP_32     = 8'd32;
    localparam logic [BYTE_W-1:0] RLE_BIAS   = 8'd127;
    localparam logic [HBC_W-1:0]  TYPE_BYTES = 5'd12;

    typedef struct packed {
        logic                valid;
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   red;
        logic [BYTE_W-1:0]   green;
        logic [BYTE_W-1:0]   blue;
        logic [BYTE_W-1:0]   alpha;
        logic [BYTE_W-1:0]   run_length;
        logic [COUNT_W-1:0]  first_index;
        logic                image_done;
        logic [DIM_W-1:0]    image_width;
        logic [DIM_W-1:0]    image_height;
        logic                has_alpha;
    } tgad_result_t;

endpackage

[rtl/core/tga_image_stream_decoder_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tga_image_stream_decoder_unit
// Byte-stream TGA decoder: header checks, raw and RLE pixel runs.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one file byte per beat; tuser marks the first byte of a
//   file, tlast the last available byte. m_axis carries zero or one result
//   per input byte: a pixel run (color, run length, first index), the
//   accepted header (width, height, alpha flag) or an error code in tuser.
//   m_axis_tlast is set on the run that completes the image.
// Timing:
//   Bytes are registered at the input, decoded in one pass by the parser and
//   registered at the output. One byte is taken per cycle, sustained, while
//   m_axis_tready stays high; bytes that give no result still step through
//   the output slot.
// Reset and stall:
//   After reset the parser ignores bytes until one arrives with tuser set.
//   While a result waits for m_axis_tready, the input register keeps its byte
//   and s_axis_tready stays low until the result is taken; an empty input
//   register still takes one byte first.
// ----------------------------------------------------------------------------
module tga_image_stream_decoder_unit
    import tgad_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic                   s_axis_tuser,   // file_start
    input  logic                   s_axis_tlast,   // file_end
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha, [39:32] run_length,
    // [71:40] first_index, [87:72] image_width, [103:88] image_height,
    // [104] has_alpha, [111:105] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic [STATUS_W-1:0]    m_axis_tuser,   // [2:0] status
    output logic                   m_axis_tlast    // image_done
);

    logic               in_valid_reg;
    logic [BYTE_W-1:0]  in_byte_reg;
    logic               in_start_reg;
    logic               in_end_reg;
    logic               out_valid_reg;
    tgad_result_t       out_reg;
    tgad_result_t       res;
    logic               advance;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    tgad_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (advance),
        .data_byte  (in_byte_reg),
        .file_start (in_start_reg),
        .file_end   (in_end_reg),
        .result     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_byte_reg  <= s_axis_tdata[BYTE_W-1:0];
            in_start_reg <= s_axis_tuser;
            in_end_reg   <= s_axis_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= res.valid;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.status;
    assign m_axis_tlast  = out_reg.image_done;
    assign m_axis_tdata  = {7'd0, out_reg.has_alpha, out_reg.image_height,
                            out_reg.image_width, out_reg.first_index,
                            out_reg.run_length, out_reg.alpha, out_reg.blue,
                            out_reg.green, out_reg.red};

endmodule

[rtl/core/tgad_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgad_parser
// Per-file parse state and the single-pass decode of one byte.
// ----------------------------------------------------------------------------
module tgad_parser
    import tgad_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step,
    input  logic [BYTE_W-1:0]  data_byte,
    input  logic               file_start,
    input  logic               file_end,
    output tgad_result_t       result
);

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [HBC_W-1:0]   hbc_reg, hbc_next;
    logic               compressed_reg, compressed_next;
    logic [DIM_W-1:0]   width_reg, width_next;
    logic [DIM_W-1:0]   height_reg, height_next;
    logic               alpha_reg, alpha_next;
    logic [COUNT_W-1:0] total_reg, total_next;
    logic [COUNT_W-1:0] done_reg, done_next;
    logic               repeat_reg, repeat_next;
    logic [BYTE_W-1:0]  remain_reg, remain_next;
    logic [BYTE_W-1:0]  color_reg [4];
    logic [BYTE_W-1:0]  color_next [4];
    logic [1:0]         bip_reg, bip_next;
    logic               bad_reg, bad_next;

    logic [HBC_W-1:0]   info_idx;
    logic [BYTE_W-1:0]  pkt_cnt;
    logic               pkt_rep;
    logic [BYTE_W-1:0]  run;
    logic [1:0]         pix_last;

    always_comb begin
        phase_next      = phase_reg;
        hbc_next        = hbc_reg;
        compressed_next = compressed_reg;
        width_next      = width_reg;
        height_next     = height_reg;
        alpha_next      = alpha_reg;
        total_next      = total_reg;
        done_next       = done_reg;
        repeat_next     = repeat_reg;
        remain_next     = remain_reg;
        color_next      = color_reg;
        bip_next        = bip_reg;
        bad_next        = bad_reg;
        result          = '0;
        info_idx        = '0;
        pkt_cnt         = '0;
        pkt_rep         = 1'b0;
        run             = '0;
        pix_last        = '0;

        if (file_start) begin
            phase_next      = PH_TYPE;
            hbc_next        = '0;
            compressed_next = 1'b0;
            width_next      = '0;
            height_next     = '0;
            alpha_next      = 1'b0;
            total_next      = '0;
            done_next       = '0;
            repeat_next     = 1'b0;
            remain_next     = '0;
            color_next      = '{default: '0};
            bip_next        = '0;
            bad_next        = 1'b0;
        end

        case (phase_next)
            PH_TYPE: begin
                if (hbc_next == HBC_W'(2)) begin
                    if (data_byte == TYPE_RAW) begin
                        compressed_next = 1'b0;
                    end else if (data_byte == TYPE_RLE) begin
                        compressed_next = 1'b1;
                    end else begin
                        bad_next = 1'b1;
                    end
                end else if (data_byte != '0) begin
                    bad_next = 1'b1;
                end
                hbc_next = hbc_next + 1'b1;
                if (hbc_next == TYPE_BYTES) begin
                    if (bad_next) begin
                        result.valid  = 1'b1;
                        result.status = ST_BAD_TYPE;
                        phase_next    = PH_ERROR;
                    end else begin
                        phase_next = PH_INFO;
                    end
                end
            end
            PH_INFO: begin
                info_idx = hbc_next - TYPE_BYTES;
                case (info_idx)
                    HBC_W'(0): width_next  = {8'd0, data_byte};
                    HBC_W'(1): width_next  = {data_byte, width_next[7:0]};
                    HBC_W'(2): height_next = {8'd0, data_byte};
                    HBC_W'(3): height_next = {data_byte, height_next[7:0]};
                    HBC_W'(4): begin
                        alpha_next = (data_byte == BPP_32);
                        if (data_byte != BPP_24 && data_byte != BPP_32) begin
                            bad_next = 1'b1;
                        end
                    end
                    default: ;
                endcase
                hbc_next = hbc_next + 1'b1;
                if (info_idx == HBC_W'(5)) begin
                    result.valid = 1'b1;
                    if (bad_next || width_next == '0 || height_next == '0) begin
                        result.status = ST_BAD_INFO;
                        phase_next    = PH_ERROR;
                    end else begin
                        total_next    = width_next * height_next;
                        done_next     = '0;
                        bip_next      = '0;
                        result.status = ST_HDR_OK;
                        phase_next    = compressed_next ? PH_RLEHDR : PH_RAW;
                    end
                end
            end
            PH_RLEHDR: begin
                pkt_rep = data_byte[7];
                pkt_cnt = pkt_rep ? (data_byte - RLE_BIAS) : (data_byte + 1'b1);
                if ({24'd0, pkt_cnt} > (total_next - done_next)) begin
                    result.valid  = 1'b1;
                    result.status = ST_OVERFLOW;
                    phase_next    = PH_ERROR;
                end else begin
                    repeat_next = pkt_rep;
                    remain_next = pkt_cnt;
                    bip_next    = '0;
                    phase_next  = PH_RLEPIX;
                end
            end
            PH_RAW, PH_RLEPIX: begin
                color_next[bip_next] = data_byte;
                bip_next = bip_next + 1'b1;
                pix_last = alpha_next ? 2'd0 : 2'd3;
                if (bip_next == pix_last) begin
                    bip_next = '0;
                    run = (phase_next == PH_RLEPIX && repeat_next) ? remain_next : 8'd1;
                    result.valid       = 1'b1;
                    result.status      = ST_PIXEL;
                    result.red         = color_next[2];
                    result.green       = color_next[1];
                    result.blue        = color_next[0];
                    result.alpha       = alpha_next ? color_next[3] : '0;
                    result.run_length  = run;
                    result.first_index = done_next;
                    done_next = done_next + {24'd0, run};
                    if (done_next >= total_next) begin
                        result.image_done = 1'b1;
                        phase_next        = PH_DONE;
                    end else if (phase_next == PH_RLEPIX) begin
                        if (repeat_next) begin
                            phase_next = PH_RLEHDR;
                        end else begin
                            remain_next = remain_next - 1'b1;
                            if (remain_next == '0) begin
                                phase_next = PH_RLEHDR;
                            end
                        end
                    end
                end
            end
            default: ;
        endcase

        if (file_end && phase_next >= PH_TYPE && phase_next <= PH_RLEPIX) begin
            result        = '0;
            result.valid  = 1'b1;
            result.status = ST_TRUNCATED;
            phase_next    = PH_ERROR;
        end

        if (result.valid && result.status == ST_HDR_OK) begin
            result.image_width  = width_next;
            result.image_height = height_next;
            result.has_alpha    = alpha_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            hbc_reg        <= '0;
            compressed_reg <= 1'b0;
            width_reg      <= '0;
            height_reg     <= '0;
            alpha_reg      <= 1'b0;
            total_reg      <= '0;
            done_reg       <= '0;
            repeat_reg     <= 1'b0;
            remain_reg     <= '0;
            color_reg      <= '{default: '0};
            bip_reg        <= '0;
            bad_reg        <= 1'b0;
        end else if (step) begin
            phase_reg      <= phase_next;
            hbc_reg        <= hbc_next;
            compressed_reg <= compressed_next;
            width_reg      <= width_next;
            height_reg     <= height_next;
            alpha_reg      <= alpha_next;
            total_reg      <= total_next;
            done_reg       <= done_next;
            repeat_reg     <= repeat_next;
            remain_reg     <= remain_next;
            color_reg      <= color_next;
            bip_reg        <= bip_next;
            bad_reg        <= bad_next;
        end
    end

endmodule

[tb/sv/tga_image_stream_decoder_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tga_image_stream_decoder_unit_tb
// Self-checking bench for the byte-stream TGA decoder.
// ----------------------------------------------------------------------------
// Whole files are built byte by byte: type and info headers, raw pixels and
// RLE packets, plus bad headers, zero sizes, packet overflow, cut and
// restarted files and stray bytes. An in-bench decoder tracks every accepted
// beat and queues the result it implies. Each result beat is compared field
// by field with the oldest queued one. The sender runs in random bursts and
// the result side stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module tga_image_stream_decoder_unit_tb;
    import tgad_pkg::*;

    localparam int RANDOM_BEATS  = 1600;
    localparam int SETTLE_CYCLES = 8;
    localparam int TIMEOUT_NS    = 1_000_000;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              start;
        logic              last;
    } beat_t;

    logic                   aclk          = 1'b0;
    logic                   aresetn       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   s_axis_tuser  = 1'b0;
    logic                   s_axis_tlast  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [STATUS_W-1:0]    m_axis_tuser;
    logic                   m_axis_tlast;

    // decoder model state
    logic [PHASE_W-1:0] dec_phase;
    logic [HBC_W-1:0]   hdr_count;
    logic               rle_mode;
    logic [DIM_W-1:0]   img_w;
    logic [DIM_W-1:0]   img_h;
    logic               img_alpha;
    logic [COUNT_W-1:0] pix_total;
    logic [COUNT_W-1:0] pix_count;
    logic               pkt_repeat;
    logic [BYTE_W-1:0]  pkt_left;
    logic [BYTE_W-1:0]  pix_bytes [4];
    logic [1:0]         pix_pos;
    logic               hdr_err;

    tgad_result_t decoded_q[$];
    beat_t        file_beats[$];

    int        mismatches = 0;
    int        beats_sent = 0;
    int        files_sent = 0;
    int        burst_left = 0;
    bit        gaps_on    = 1'b1;
    int        status_seen [6];
    logic [15:0] rx_cycle = '0;

    always #1 aclk = ~aclk;

    tga_image_stream_decoder_unit u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        #(TIMEOUT_NS);
        $display("TIMEOUT with %0d results outstanding", decoded_q.size());
        $display("Some tests failed");
        $finish;
    end

    // result side: steady, coin-flip, periodic and bursty stall stretches
    always @(negedge aclk) begin
        rx_cycle <= rx_cycle + 16'd1;
        case (rx_cycle[10:9])
            2'd0: m_axis_tready <= 1'b1;
            2'd1: m_axis_tready <= 1'($urandom_range(0, 1));
            2'd2: m_axis_tready <= (rx_cycle[2:0] != 3'd0);
            default: begin
                m_axis_tready <= (rx_cycle[5:3] != 3'd5) && ($urandom_range(0, 7) != 0);
            end
        endcase
    end

    task automatic clear_file_model();
        hdr_count  = '0;
        rle_mode   = 1'b0;
        img_w      = '0;
        img_h      = '0;
        img_alpha  = 1'b0;
        pix_total  = '0;
        pix_count  = '0;
        pkt_repeat = 1'b0;
        pkt_left   = '0;
        foreach (pix_bytes[i]) pix_bytes[i] = '0;
        pix_pos    = '0;
        hdr_err    = 1'b0;
    endtask

    task automatic decode_byte(input logic [BYTE_W-1:0] d, input logic fs, input logic fe,
                               output bit produced, output tgad_result_t r);
        logic [STATUS_W-1:0] code;
        logic [HBC_W-1:0]    idx;
        logic [BYTE_W-1:0]   cnt;
        logic [BYTE_W-1:0]   run;
        logic                rep;
        r = '0;
        produced = 1'b0;
        code = ST_PIXEL;
        if (fs) begin
            clear_file_model();
            dec_phase = PH_TYPE;
        end
        case (dec_phase)
            PH_TYPE: begin
                if (hdr_count == 5'd2) begin
                    if (d == TYPE_RAW) rle_mode = 1'b0;
                    else if (d == TYPE_RLE) rle_mode = 1'b1;
                    else hdr_err = 1'b1;
                end else if (d != 8'd0) begin
                    hdr_err = 1'b1;
                end
                hdr_count = hdr_count + 5'd1;
                if (hdr_count == TYPE_BYTES) begin
                    if (hdr_err) begin
                        produced = 1'b1;
                        code = ST_BAD_TYPE;
                        dec_phase = PH_ERROR;
                    end else begin
                        dec_phase = PH_INFO;
                    end
                end
            end
            PH_INFO: begin
                idx = hdr_count - TYPE_BYTES;
                case (idx)
                    5'd0: img_w = {8'd0, d};
                    5'd1: img_w[15:8] = d;
                    5'd2: img_h = {8'd0, d};
                    5'd3: img_h[15:8] = d;
                    5'd4: begin
                        img_alpha = (d == BPP_32);
                        if (d != BPP_24 && d != BPP_32) hdr_err = 1'b1;
                    end
                    default: ;
                endcase
                hdr_count = hdr_count + 5'd1;
                if (idx == 5'd5) begin
                    produced = 1'b1;
                    if (hdr_err || img_w == 0 || img_h == 0) begin
                        code = ST_BAD_INFO;
                        dec_phase = PH_ERROR;
                    end else begin
                        pix_total = 32'(img_w) * 32'(img_h);
                        pix_count = '0;
                        pix_pos = '0;
                        code = ST_HDR_OK;
                        dec_phase = rle_mode ? PH_RLEHDR : PH_RAW;
                    end
                end
            end
            PH_RLEHDR: begin
                rep = d[7];
                cnt = rep ? d - RLE_BIAS : d + 8'd1;
                if (32'(cnt) > pix_total - pix_count) begin
                    produced = 1'b1;
                    code = ST_OVERFLOW;
                    dec_phase = PH_ERROR;
                end else begin
                    pkt_repeat = rep;
                    pkt_left = cnt;
                    pix_pos = '0;
                    dec_phase = PH_RLEPIX;
                end
            end
            PH_RAW, PH_RLEPIX: begin
                pix_bytes[pix_pos] = d;
                pix_pos = pix_pos + 2'd1;
                if (pix_pos == (img_alpha ? 2'd0 : 2'd3)) begin
                    pix_pos = '0;
                    run = (dec_phase == PH_RLEPIX && pkt_repeat) ? pkt_left : 8'd1;
                    r.red = pix_bytes[2];
                    r.green = pix_bytes[1];
                    r.blue = pix_bytes[0];
                    r.alpha = img_alpha ? pix_bytes[3] : 8'd0;
                    r.run_length = run;
                    r.first_index = pix_count;
                    pix_count = pix_count + 32'(run);
                    produced = 1'b1;
                    code = ST_PIXEL;
                    if (pix_count >= pix_total) begin
                        r.image_done = 1'b1;
                        dec_phase = PH_DONE;
                    end else if (dec_phase == PH_RLEPIX) begin
                        if (pkt_repeat) begin
                            dec_phase = PH_RLEHDR;
                        end else begin
                            pkt_left = pkt_left - 8'd1;
                            if (pkt_left == 0) dec_phase = PH_RLEHDR;
                        end
                    end
                end
            end
            default: ;
        endcase
        // a cut file overrides any pixel or header result of this byte
        if (fe && dec_phase >= PH_TYPE && dec_phase <= PH_RLEPIX) begin
            r = '0;
            produced = 1'b1;
            code = ST_TRUNCATED;
            dec_phase = PH_ERROR;
        end
        r.status = code;
        if (code == ST_HDR_OK) begin
            r.image_width = img_w;
            r.image_height = img_h;
            r.has_alpha = img_alpha;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("MISMATCH %s: expected 0x%0h, got 0x%0h at %0t ns", what, want, got, $time);
        mismatches++;
    endtask

    task automatic compare_field(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) report_mismatch(what, want, got);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (m_axis_tuser <= ST_TRUNCATED) status_seen[m_axis_tuser]++;
            if (decoded_q.size() == 0) begin
                report_mismatch("result with nothing pending, status", '0, 32'(m_axis_tuser));
            end else begin
                tgad_result_t e;
                e = decoded_q.pop_front();
                compare_field("status", 32'(e.status), 32'(m_axis_tuser));
                compare_field("red", 32'(e.red), 32'(m_axis_tdata[7:0]));
                compare_field("green", 32'(e.green), 32'(m_axis_tdata[15:8]));
                compare_field("blue", 32'(e.blue), 32'(m_axis_tdata[23:16]));
                compare_field("alpha", 32'(e.alpha), 32'(m_axis_tdata[31:24]));
                compare_field("run_length", 32'(e.run_length), 32'(m_axis_tdata[39:32]));
                compare_field("first_index", e.first_index, m_axis_tdata[71:40]);
                compare_field("image_width", 32'(e.image_width), 32'(m_axis_tdata[87:72]));
                compare_field("image_height", 32'(e.image_height), 32'(m_axis_tdata[103:88]));
                compare_field("has_alpha", 32'(e.has_alpha), 32'(m_axis_tdata[104]));
                compare_field("tdata pad", '0, 32'(m_axis_tdata[111:105]));
                compare_field("image_done", 32'(e.image_done), 32'(m_axis_tlast));
            end
        end
    end

    // one beat; tvalid stays high into the next call unless a gap is drawn
    task automatic send_beat(input beat_t b);
        bit           produced;
        tgad_result_t r;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            if (gaps_on) begin
                @(negedge aclk);
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(0, 5)) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b.data;
        s_axis_tuser  <= b.start;
        s_axis_tlast  <= b.last;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        decode_byte(b.data, b.start, b.last, produced, r);
        if (produced) decoded_q.push_back(r);
        beats_sent++;
        if (b.start) files_sent++;
    endtask

    task automatic send_file();
        foreach (file_beats[i]) send_beat(file_beats[i]);
        file_beats.delete();
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic void push_byte(input logic [7:0] d);
        file_beats.push_back('{d, 1'b0, 1'b0});
    endfunction

    function automatic void mark_end();
        beat_t b;
        b = file_beats.pop_back();
        b.last = 1'b1;
        file_beats.push_back(b);
    endfunction

    function automatic void add_type_header(input logic [7:0] kind);
        file_beats.push_back('{8'd0, 1'b1, 1'b0});
        for (int i = 1; i < TYPE_BYTES; i++) push_byte(i == 2 ? kind : 8'd0);
    endfunction

    function automatic void add_info(input logic [15:0] w, input logic [15:0] h,
                                     input logic [7:0] bpp);
        push_byte(w[7:0]);
        push_byte(w[15:8]);
        push_byte(h[7:0]);
        push_byte(h[15:8]);
        push_byte(bpp);
        push_byte(8'($urandom));
    endfunction

    function automatic void add_pixel(input logic alpha);
        repeat (alpha ? 4 : 3) push_byte(rand_byte());
    endfunction

    function automatic void add_raw_body(input int n, input logic alpha);
        repeat (n) add_pixel(alpha);
    endfunction

    // long_runs: mostly repeat packets near full length, short literals
    function automatic void add_rle_body(input int n, input logic alpha, input bit long_runs);
        int rem;
        int maxc;
        int cnt;
        bit rep;
        rem = n;
        while (rem > 0) begin
            maxc = rem > 128 ? 128 : rem;
            rep = long_runs ? ($urandom_range(0, 9) != 0) : 1'($urandom_range(0, 1));
            if (long_runs && rep) cnt = $urandom_range(maxc > 64 ? 64 : 1, maxc);
            else if ($urandom_range(0, 3) == 0) cnt = $urandom_range(1, maxc);
            else cnt = $urandom_range(1, maxc < 4 ? maxc : 4);
            push_byte(rep ? 8'(cnt + 127) : 8'(cnt - 1));
            repeat (rep ? 1 : cnt) add_pixel(alpha);
            rem -= cnt;
        end
    endfunction

    task automatic test_stray_bytes();
        push_byte(8'hFF);
        push_byte(8'h00);
        push_byte(8'h0A);
        mark_end();
        send_file();
        wait_drained();
    endtask

    task automatic test_raw_24bit();
        add_type_header(TYPE_RAW);
        add_info(16'd2, 16'd1, BPP_24);
        push_byte(8'hFF); push_byte(8'h00); push_byte(8'h80);
        push_byte(8'hFF); push_byte(8'hFF); push_byte(8'hFF);
        mark_end();
        push_byte(8'h55);   // after image done: ignored
        send_file();
        wait_drained();
    endtask

    task automatic test_rle_32bit();
        add_type_header(TYPE_RLE);
        add_info(16'd130, 16'd1, BPP_32);
        push_byte(8'hFF);   // repeat of 128
        repeat (4) push_byte(8'h00);
        push_byte(8'h01);   // literal of 2
        repeat (4) push_byte(8'hFF);
        push_byte(8'h78); push_byte(8'h56); push_byte(8'h34); push_byte(8'h12);
        send_file();
        wait_drained();
    endtask

    task automatic test_header_errors();
        add_type_header(8'd3);
        add_pixel(1'b0);
        add_type_header(TYPE_RAW);
        begin
            beat_t b;
            b = file_beats[file_beats.size() - 5];
            b.data = 8'h80;
            file_beats[file_beats.size() - 5] = b;
        end
        add_type_header(TYPE_RAW);
        add_info(16'd1, 16'd1, 8'd16);
        add_type_header(TYPE_RLE);
        add_info(16'd0, 16'd5, BPP_24);
        add_type_header(TYPE_RAW);
        add_info(16'd5, 16'd0, BPP_32);
        send_file();
        wait_drained();
    endtask

    task automatic test_overflow();
        add_type_header(TYPE_RLE);
        add_info(16'd2, 16'd2, BPP_24);
        push_byte(8'h84);   // 5 copies into 4 pixels
        add_pixel(1'b0);
        add_type_header(TYPE_RLE);
        add_info(16'd2, 16'd1, BPP_24);
        push_byte(8'h00);
        add_pixel(1'b0);
        push_byte(8'h01);   // literal of 2 with 1 left
        send_file();
        wait_drained();
    endtask

    task automatic test_truncation();
        add_type_header(TYPE_RAW);
        void'(file_beats.pop_back());
        repeat (6) void'(file_beats.pop_back());
        mark_end();
        add_type_header(TYPE_RLE);
        add_info(16'd3, 16'd3, BPP_32);
        mark_end();         // replaces header accepted
        add_type_header(TYPE_RAW);
        add_info(16'd3, 16'd1, BPP_24);
        add_pixel(1'b0);
        add_pixel(1'b0);
        mark_end();         // replaces a pixel
        add_type_header(TYPE_RLE);
        mark_end();         // cut on the last type header byte
        add_type_header(TYPE_RAW);
        add_info(16'd1, 16'd1, 8'd8);
        mark_end();         // bad info wins
        add_type_header(TYPE_RLE);
        add_info(16'd4, 16'd1, BPP_24);
        push_byte(8'h80);
        add_pixel(1'b0);
        push_byte(8'h02);
        mark_end();         // cut on a packet header
        send_file();
        wait_drained();
    endtask

    task automatic test_max_dimensions();
        add_type_header(TYPE_RAW);
        add_info(16'hFFFF, 16'hFFFF, BPP_32);
        add_pixel(1'b1);
        add_pixel(1'b1);
        mark_end();
        send_file();
        wait_drained();
    endtask

    task automatic test_restart();
        add_type_header(TYPE_RAW);
        add_info(16'd3, 16'd1, BPP_24);
        add_pixel(1'b0);
        push_byte(8'h11);
        add_type_header(TYPE_RAW);   // new file mid pixel
        add_info(16'd1, 16'd1, BPP_24);
        add_pixel(1'b0);
        send_file();
        wait_drained();
    endtask

    task automatic build_random_file();
        int   pick;
        int   w;
        int   h;
        int   n;
        int   done_px;
        int   rem;
        int   cnt;
        int   k;
        bit   rep;
        logic rle;
        logic alpha;
        beat_t b;
        pick  = $urandom_range(0, 99);
        alpha = 1'($urandom_range(0, 1));
        rle   = (pick < 8 || (pick >= 80 && pick < 88)) ? 1'b1 : 1'($urandom_range(0, 1));
        if (pick < 8) begin
            w = $urandom_range(16, 64);
            h = $urandom_range(16, 64);
        end else if (pick >= 92 && pick < 95) begin
            w = $urandom_range(1000, 65535);
            h = $urandom_range(1000, 65535);
        end else begin
            w = $urandom_range(1, 6);
            h = $urandom_range(1, 4);
        end
        if (pick >= 88 && pick < 92) begin
            if ($urandom_range(0, 1)) w = 0;
            else h = 0;
        end
        add_type_header(rle ? TYPE_RLE : TYPE_RAW);
        add_info(16'(w), 16'(h), alpha ? BPP_32 : BPP_24);
        n = w * h;
        if (n == 0) begin
            add_pixel(alpha);
        end else if (pick >= 80 && pick < 88) begin
            done_px = $urandom_range(0, n - 1);
            add_rle_body(done_px, alpha, 1'b0);
            rem = n - done_px;
            cnt = $urandom_range(rem + 1, 128);
            rep = 1'($urandom_range(0, 1));
            push_byte(rep ? 8'(cnt + 127) : 8'(cnt - 1));
            add_pixel(alpha);
        end else if (pick >= 92 && pick < 95) begin
            if (rle) add_rle_body(6, alpha, 1'b0);
            else add_raw_body(3, alpha);
            mark_end();
        end else if (rle) begin
            add_rle_body(n, alpha, pick < 8);
        end else begin
            add_raw_body(n, alpha);
        end
        if (pick >= 70 && pick < 80) begin
            k = $urandom_range(0, file_beats.size() - 1);
            while (file_beats.size() > k + 1) void'(file_beats.pop_back());
            if ($urandom_range(0, 1)) mark_end();
        end else if (pick >= 95) begin
            k = $urandom_range(0, 17);
            b = file_beats[k];
            b.data = 8'($urandom);
            file_beats[k] = b;
        end else if (pick >= 8 && pick < 70) begin
            if ($urandom_range(0, 1)) mark_end();
            if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 3)) push_byte(rand_byte());
        end
    endtask

    task automatic test_random_files();
        int stop_at;
        stop_at = beats_sent + RANDOM_BEATS;
        while (beats_sent < stop_at) begin
            gaps_on = ($urandom_range(0, 2) != 0);
            build_random_file();
            send_file();
            if ($urandom_range(0, 15) == 0) wait_drained();
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        dec_phase = PH_IDLE;
        clear_file_model();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_stray_bytes();
        test_raw_24bit();
        test_rle_32bit();
        test_header_errors();
        test_overflow();
        test_truncation();
        test_max_dimensions();
        test_restart();
        test_random_files();
        wait_drained();

        $display("Fed %0d beats in %0d files; results: %0d pixel runs, %0d headers accepted",
                 beats_sent, files_sent, status_seen[ST_PIXEL], status_seen[ST_HDR_OK]);
        $display("Errors seen: %0d bad type, %0d bad info, %0d overflow, %0d truncated",
                 status_seen[ST_BAD_TYPE], status_seen[ST_BAD_INFO],
                 status_seen[ST_OVERFLOW], status_seen[ST_TRUNCATED]);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
